>>> hdl/rpwu_pkg.sv
// Package for the Rprop weight update block: sizes, codes, reset values and
// the structs passed between the front, back and output buffer modules.
// No dependencies.
`default_nettype none

package rpwu_pkg;

  localparam int CHAINS    = 2;
  localparam int STAGES    = 64;
  localparam int ENTRIES   = CHAINS * STAGES;
  localparam int IDX_W     = 7;
  localparam int MEM_DEPTH = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int WEIGHT_W  = 32;
  localparam int STEP_W    = 23;
  localparam int FACTOR_W  = 18;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = STEP_W + FACTOR_W;
  localparam int SCALED_W  = PROD_W - FRAC_W;
  localparam int SIGN_W    = 2;
  localparam int ACT_W     = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));
  localparam logic [STEP_W-1:0] STEP_ALL_ONES = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_INC_FACTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INIT  = 3'd4;

  localparam logic [FACTOR_W-1:0] INC_FACTOR_RST = 18'd78643;
  localparam logic [FACTOR_W-1:0] DEC_FACTOR_RST = 18'd32768;
  localparam logic [STEP_W-1:0]   STEP_MAX_RST   = 23'd6553600;
  localparam logic [STEP_W-1:0]   STEP_MIN_RST   = 23'd66;
  localparam logic [STEP_W-1:0]   STEP_INIT_RST  = 23'd6554;

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_GROW = 2'd1,
    ACT_BACK = 2'd2,
    ACT_KEEP = 2'd3
  } action_t;

  typedef struct packed {
    op_t                        op;
    logic [IDX_W-1:0]           idx;
    logic signed [WEIGHT_W-1:0] value;
    logic                       in_range;
    logic                       grad_neg;
    logic                       grad_zero;
  } item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [STEP_W-1:0]          step;
    logic [SIGN_W-1:0]          sign;
    logic signed [WEIGHT_W-1:0] change;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]           idx;
    logic signed [WEIGHT_W-1:0] weight;
    logic [STEP_W-1:0]          step;
    action_t                    action;
  } result_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 full;
  } ob_status_t;

  typedef struct packed {
    logic       issue;
    logic [1:0] inflight;
  } back_status_t;

endpackage

`default_nettype wire

>>> hdl/rprop_weight_update.sv
// Rprop+ weight update top level: front queue, back pipeline, output buffer.
// One request per cycle unless issue stalls on an update hazard or output buffer credit.
// An update to the same entry as either of the two requests ahead of it in the back
// pipeline waits until their write-back to the entry memory is done.
// Synchronous active-low reset clears queues, pipeline valids and config to defaults;
// the entry memory is not cleared and an entry reads as undefined until loaded.
`default_nettype none

module rprop_weight_update (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rpwu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rpwu_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic [rpwu_pkg::IDX_W-1:0]            in_entry_index,
  input  logic signed [rpwu_pkg::WEIGHT_W-1:0]  in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rpwu_pkg::IDX_W-1:0]            out_result_index,
  output logic signed [rpwu_pkg::WEIGHT_W-1:0]  out_new_weight,
  output logic [rpwu_pkg::STEP_W-1:0]           out_new_step,
  output logic [rpwu_pkg::ACT_W-1:0]            out_action
);

  logic                   q_valid;
  logic                   q_ready;
  rpwu_pkg::item_t        q_item;
  logic                   res_valid;
  rpwu_pkg::result_t      res_item;
  rpwu_pkg::ob_status_t   ob_status;
  rpwu_pkg::back_status_t back_status;
  rpwu_pkg::result_t      out_item;

  rpwu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item)
  );

  rpwu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .ob_status (ob_status),
    .res_valid (res_valid),
    .res_item  (res_item),
    .status    (back_status)
  );

  rpwu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .status    (ob_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_result_index = out_item.idx;
  assign out_new_weight   = out_item.weight;
  assign out_new_step     = out_item.step;
  assign out_action       = out_item.action;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !ob_status.full)
    else $error("result pushed into a full output buffer");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(ob_status.count) + int'(back_status.inflight)) <= rpwu_pkg::OUT_DEPTH)
    else $error("in-flight requests exceed output buffer room");

  a_issue_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    back_status.issue |=> (back_status.inflight != 2'd0))
    else $error("issued request not tracked in the back pipeline");

endmodule

`default_nettype wire

>>> hdl/rpwu_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on rpwu_pkg.
`default_nettype none

module rpwu_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic [rpwu_pkg::IDX_W-1:0]            in_entry_index,
  input  logic signed [rpwu_pkg::WEIGHT_W-1:0]  in_value,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output rpwu_pkg::item_t                       q_item
);

  localparam int QAW = (rpwu_pkg::QUEUE_DEPTH > 1) ? $clog2(rpwu_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(rpwu_pkg::QUEUE_DEPTH + 1);

  rpwu_pkg::item_t queue_r [rpwu_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QCW-1:0]  count_r;
  rpwu_pkg::item_t item_in;
  logic            push;
  logic            pop;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] ptr);
    logic [QAW-1:0] res;
    if (ptr == QAW'(rpwu_pkg::QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    item_in.op        = rpwu_pkg::op_t'(in_operation);
    item_in.idx       = in_entry_index;
    item_in.value     = in_value;
    item_in.in_range  = (32'(in_entry_index) < rpwu_pkg::MEM_DEPTH);
    item_in.grad_neg  = in_value[rpwu_pkg::WEIGHT_W-1];
    item_in.grad_zero = (in_value == '0);
  end

  assign in_ready = (count_r < QCW'(rpwu_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpwu_back.sv
// Back end: configuration registers, entry memory and the read, multiply and
// write-back pipeline that carries out loads and updates. Depends on rpwu_pkg.
`default_nettype none

module rpwu_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rpwu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rpwu_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  rpwu_pkg::item_t                       q_item,
  input  rpwu_pkg::ob_status_t                  ob_status,
  output logic                                  res_valid,
  output rpwu_pkg::result_t                     res_item,
  output rpwu_pkg::back_status_t                status
);

  logic [rpwu_pkg::FACTOR_W-1:0] inc_factor_r;
  logic [rpwu_pkg::FACTOR_W-1:0] dec_factor_r;
  logic [rpwu_pkg::STEP_W-1:0]   step_max_r;
  logic [rpwu_pkg::STEP_W-1:0]   step_min_r;
  logic [rpwu_pkg::STEP_W-1:0]   step_init_r;

  rpwu_pkg::entry_t  entry_mem_r [rpwu_pkg::MEM_DEPTH];
  rpwu_pkg::entry_t  rd_data_r;

  logic              s1_valid_r;
  rpwu_pkg::item_t   s1_item_r;
  logic              s2_valid_r;
  rpwu_pkg::item_t   s2_item_r;
  rpwu_pkg::entry_t  s2_entry_r;
  rpwu_pkg::action_t s2_action_r;
  logic [rpwu_pkg::PROD_W-1:0] s2_prod_r;

  logic              hazard;
  logic              credit_ok;
  logic              issue;
  logic              same_sign;
  logic              opp_sign;
  rpwu_pkg::action_t s1_action;
  logic [rpwu_pkg::FACTOR_W-1:0] s1_factor;
  logic [rpwu_pkg::PROD_W-1:0]   s1_prod;

  logic [rpwu_pkg::SCALED_W-1:0] scaled;
  logic [rpwu_pkg::STEP_W-1:0]   grown;
  logic [rpwu_pkg::STEP_W-1:0]   shrunk;
  logic [rpwu_pkg::STEP_W-1:0]   move_step;
  logic signed [rpwu_pkg::WEIGHT_W-1:0] move_change;
  logic signed [rpwu_pkg::WEIGHT_W:0]   weight_sum;
  logic signed [rpwu_pkg::WEIGHT_W-1:0] weight_sat;
  rpwu_pkg::entry_t  wr_entry;
  logic              wr_en;

  // The user must write configuration only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_factor_r <= rpwu_pkg::INC_FACTOR_RST;
      dec_factor_r <= rpwu_pkg::DEC_FACTOR_RST;
      step_max_r   <= rpwu_pkg::STEP_MAX_RST;
      step_min_r   <= rpwu_pkg::STEP_MIN_RST;
      step_init_r  <= rpwu_pkg::STEP_INIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpwu_pkg::CFG_INC_FACTOR: inc_factor_r <= cfg_data[rpwu_pkg::FACTOR_W-1:0];
        rpwu_pkg::CFG_DEC_FACTOR: dec_factor_r <= cfg_data[rpwu_pkg::FACTOR_W-1:0];
        rpwu_pkg::CFG_STEP_MAX:   step_max_r   <= cfg_data[rpwu_pkg::STEP_W-1:0];
        rpwu_pkg::CFG_STEP_MIN:   step_min_r   <= cfg_data[rpwu_pkg::STEP_W-1:0];
        rpwu_pkg::CFG_STEP_INIT:  step_init_r  <= cfg_data[rpwu_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // An update must not read an entry that an older request has yet to write.
  always_comb begin
    hazard = (q_item.op == rpwu_pkg::OP_UPDATE) && q_item.in_range &&
             ((s1_valid_r && s1_item_r.in_range && (s1_item_r.idx == q_item.idx)) ||
              (s2_valid_r && s2_item_r.in_range && (s2_item_r.idx == q_item.idx)));
    credit_ok = (int'(ob_status.count) + int'(s1_valid_r) + int'(s2_valid_r))
                < rpwu_pkg::OUT_DEPTH;
  end

  assign q_ready = !hazard && credit_ok;
  assign issue   = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= entry_mem_r[q_item.idx[rpwu_pkg::MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[s2_item_r.idx[rpwu_pkg::MEM_AW-1:0]] <= wr_entry;
    end
  end

  always_comb begin
    same_sign = !s1_item_r.grad_zero && (rd_data_r.sign != rpwu_pkg::SIGN_ZERO) &&
                (s1_item_r.grad_neg == rd_data_r.sign[rpwu_pkg::SIGN_W-1]);
    opp_sign  = !s1_item_r.grad_zero && (rd_data_r.sign != rpwu_pkg::SIGN_ZERO) &&
                (s1_item_r.grad_neg != rd_data_r.sign[rpwu_pkg::SIGN_W-1]);
    if (!s1_item_r.in_range) begin
      s1_action = (s1_item_r.op == rpwu_pkg::OP_UPDATE) ? rpwu_pkg::ACT_KEEP
                                                          : rpwu_pkg::ACT_LOAD;
    end else if (s1_item_r.op == rpwu_pkg::OP_LOAD) begin
      s1_action = rpwu_pkg::ACT_LOAD;
    end else if (same_sign) begin
      s1_action = rpwu_pkg::ACT_GROW;
    end else if (opp_sign) begin
      s1_action = rpwu_pkg::ACT_BACK;
    end else begin
      s1_action = rpwu_pkg::ACT_KEEP;
    end
    s1_factor = same_sign ? inc_factor_r : dec_factor_r;
    s1_prod   = rpwu_pkg::PROD_W'(rd_data_r.step) * rpwu_pkg::PROD_W'(s1_factor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r <= q_item;
    end
    if (s1_valid_r) begin
      s2_item_r   <= s1_item_r;
      s2_entry_r  <= rd_data_r;
      s2_action_r <= s1_action;
      s2_prod_r   <= s1_prod;
    end
  end

  always_comb begin
    scaled = rpwu_pkg::SCALED_W'((s2_prod_r + rpwu_pkg::ROUND_HALF) >> rpwu_pkg::FRAC_W);
    if (scaled > rpwu_pkg::SCALED_W'(step_max_r)) begin
      grown = step_max_r;
    end else begin
      grown = scaled[rpwu_pkg::STEP_W-1:0];
    end
    if (scaled < rpwu_pkg::SCALED_W'(step_min_r)) begin
      shrunk = step_min_r;
    end else if (scaled > rpwu_pkg::SCALED_W'(rpwu_pkg::STEP_ALL_ONES)) begin
      shrunk = rpwu_pkg::STEP_ALL_ONES;
    end else begin
      shrunk = scaled[rpwu_pkg::STEP_W-1:0];
    end

    move_step = (s2_action_r == rpwu_pkg::ACT_GROW) ? grown : s2_entry_r.step;
    if (s2_item_r.grad_zero) begin
      move_change = '0;
    end else if (s2_item_r.grad_neg) begin
      move_change = -$signed(rpwu_pkg::WEIGHT_W'(move_step));
    end else begin
      move_change = $signed(rpwu_pkg::WEIGHT_W'(move_step));
    end

    if (s2_action_r == rpwu_pkg::ACT_BACK) begin
      weight_sum = $signed({s2_entry_r.weight[rpwu_pkg::WEIGHT_W-1], s2_entry_r.weight}) -
                   $signed({s2_entry_r.change[rpwu_pkg::WEIGHT_W-1], s2_entry_r.change});
    end else begin
      weight_sum = $signed({s2_entry_r.weight[rpwu_pkg::WEIGHT_W-1], s2_entry_r.weight}) +
                   $signed({move_change[rpwu_pkg::WEIGHT_W-1], move_change});
    end
    if (weight_sum[rpwu_pkg::WEIGHT_W] != weight_sum[rpwu_pkg::WEIGHT_W-1]) begin
      weight_sat = weight_sum[rpwu_pkg::WEIGHT_W] ?
                   $signed({1'b1, {(rpwu_pkg::WEIGHT_W-1){1'b0}}}) :
                   $signed({1'b0, {(rpwu_pkg::WEIGHT_W-1){1'b1}}});
    end else begin
      weight_sat = weight_sum[rpwu_pkg::WEIGHT_W-1:0];
    end

    unique case (s2_action_r)
      rpwu_pkg::ACT_LOAD: begin
        wr_entry.weight = s2_item_r.value;
        wr_entry.step   = step_init_r;
        wr_entry.sign   = rpwu_pkg::SIGN_POS;
        wr_entry.change = '0;
      end
      rpwu_pkg::ACT_BACK: begin
        wr_entry.weight = weight_sat;
        wr_entry.step   = shrunk;
        wr_entry.sign   = rpwu_pkg::SIGN_ZERO;
        wr_entry.change = s2_entry_r.change;
      end
      default: begin
        wr_entry.weight = weight_sat;
        wr_entry.step   = move_step;
        wr_entry.sign   = s2_item_r.grad_zero ? rpwu_pkg::SIGN_ZERO :
                          (s2_item_r.grad_neg ? rpwu_pkg::SIGN_NEG : rpwu_pkg::SIGN_POS);
        wr_entry.change = move_change;
      end
    endcase

    wr_en              = s2_valid_r && s2_item_r.in_range;
    res_valid          = s2_valid_r;
    res_item.idx       = s2_item_r.idx;
    res_item.action    = s2_action_r;
    res_item.weight    = s2_item_r.in_range ? wr_entry.weight : '0;
    res_item.step      = s2_item_r.in_range ? wr_entry.step : '0;
    status.issue       = issue;
    status.inflight    = {1'b0, s1_valid_r} + {1'b0, s2_valid_r};
  end

endmodule

`default_nettype wire

>>> hdl/rpwu_out_buf.sv
// Output buffer: small FIFO of finished results toward the consumer; its fill
// level gives the back end its issue credit. Depends on rpwu_pkg.
`default_nettype none

module rpwu_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  rpwu_pkg::result_t    res_item,
  output rpwu_pkg::ob_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rpwu_pkg::result_t    out_item
);

  localparam int OAW = (rpwu_pkg::OUT_DEPTH > 1) ? $clog2(rpwu_pkg::OUT_DEPTH) : 1;

  rpwu_pkg::result_t             fifo_r [rpwu_pkg::OUT_DEPTH];
  logic [OAW-1:0]                wr_ptr_r;
  logic [OAW-1:0]                rd_ptr_r;
  logic [rpwu_pkg::OUT_CNT_W-1:0] count_r;
  logic                          pop;

  function automatic logic [OAW-1:0] ptr_inc(input logic [OAW-1:0] ptr);
    logic [OAW-1:0] res;
    if (ptr == OAW'(rpwu_pkg::OUT_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  assign out_valid    = (count_r != '0);
  assign out_item     = fifo_r[rd_ptr_r];
  assign pop          = out_valid && out_ready;
  assign status.count = count_r;
  assign status.full  = (count_r == rpwu_pkg::OUT_CNT_W'(rpwu_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_r[wr_ptr_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (res_valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !res_valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
